FILE: hdl/pisg_pkg.sv
// shared constants for the pi spigot digit generator
// no dependencies; imported by pi_spigot_digit_generator
package pisg_pkg;

	localparam int MAX_TERMS_DEF = 4096;
	localparam int TERM_COUNT_W = 13;
	localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RST = 13'd4096;
	localparam int DIGIT_W = 4;
	localparam int NINES_W = 12;
	localparam logic [NINES_W-1:0] NINES_MAX = 12'd4095;
	localparam int CARRY_W = 8;
	localparam int QSTEPS = CARRY_W;
	localparam logic [63:0] PREC_BOUND = 64'h0fff_ffff_ffff_ffff;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
	localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
	localparam logic [CARRY_W-1:0] CARRY_NINE = 8'd9;
	localparam logic [CARRY_W-1:0] CARRY_TEN = 8'd10;
	localparam int TERM_INIT = 2;
	localparam int RADIX = 10;

endpackage

FILE: hdl/pisg_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies; used for the spigot term store
module pisg_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pi_spigot_digit_generator.sv
// pi spigot digit generator: one decimal digit of pi per request word
// sequence: a clearing pass over all MAX_TERMS terms after reset and on every restart word;
// a held 0 or 9 is released without a spigot pass; a spigot pass over n active terms
// does read, multiply-add, 8 restoring divide steps and write-back per term;
// each held nine adds another full pass
// throughput: one word at a time, set by the shared divide unit and the output register
module pi_spigot_digit_generator
	import pisg_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [TERM_COUNT_W-1:0] term_count,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    restart,
	// digit channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DIGIT_W-1:0]      digit,
	output logic                    overflow_flag
);

	// widths that follow from the store depth
	localparam int AW = $clog2(MAX_TERMS);          // store address
	localparam int IW = $clog2(MAX_TERMS + 1);      // term index, holds MAX_TERMS
	localparam int TW = AW + 2;                     // stored remainder, below 2*MAX_TERMS
	localparam int DW = IW + 1;                     // divisor 2i-1
	localparam int XW = IW + 9;                     // 10*term + carry*i
	localparam int CW = (IW > TERM_COUNT_W) ? IW : TERM_COUNT_W;
	localparam int KW = $clog2(QSTEPS);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_MAC,
		ST_DIV,
		ST_WRITE,
		ST_EMIT
	} state_t;

	// digit release phases
	typedef enum logic [1:0] {
		PH_COMPUTE = 2'd0,
		PH_ZEROS   = 2'd1,
		PH_NINES   = 2'd2,
		PH_SPARE   = 2'd3
	} phase_t;

	state_t                 state_q;
	phase_t                 phase_q;
	logic [TERM_COUNT_W-1:0] term_count_q;
	logic [AW-1:0]          clr_addr_q;
	logic                   pend_q;        // request waiting behind a clearing pass
	logic [IW-1:0]          idx_q;         // current term index i
	logic [CARRY_W-1:0]     carry_q;       // carry passed down the terms
	logic [XW-1:0]          rem_q;         // divide remainder
	logic [XW-1:0]          dsh_q;         // shifted divisor
	logic [DW-1:0]          div_q;         // divisor of the current step
	logic [CARRY_W-1:0]     quot_q;
	logic [KW-1:0]          k_q;
	logic                   final_q;       // divide of the last carry by 10
	logic [NINES_W-1:0]     nines_q;
	logic [NINES_W-1:0]     run_q;
	logic [DIGIT_W-1:0]     pred_q;
	logic                   ovf_q;
	logic [DIGIT_W-1:0]     res_q;         // digit waiting for the output register
	logic                   out_valid_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic                   oflag_q;

	// term store
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [TW-1:0]          ram_wdata;
	logic                   ram_re;
	logic [TW-1:0]          ram_rdata;

	logic [CW-1:0]          tc_ext;
	logic [IW-1:0]          active_c;
	logic [XW-1:0]          x_c;
	logic [CARRY_W+IW-1:0]  prod_c;
	logic [TW+3:0]          t10_c;
	logic [XW-1:0]          rem_sub_c;
	logic                   ge_c;

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign digit         = digit_q;
	assign overflow_flag = oflag_q;

	// term count clamped to 1..MAX_TERMS
	always_comb begin
		tc_ext = CW'(term_count_q);
		if (tc_ext == '0) begin
			active_c = IW'(1);
		end else if (tc_ext > CW'(MAX_TERMS)) begin
			active_c = IW'(MAX_TERMS);
		end else begin
			active_c = tc_ext[IW-1:0];
		end
	end

	// x = 10*term + carry*i
	always_comb begin
		t10_c  = {ram_rdata, 3'b000} + {2'b00, ram_rdata, 1'b0};
		prod_c = carry_q * idx_q;
		x_c    = XW'(t10_c) + XW'(prod_c);
	end

	// one restoring divide step
	assign ge_c      = (rem_q >= dsh_q);
	assign rem_sub_c = rem_q - dsh_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = TW'(TERM_INIT);
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = final_q ? '0 : AW'(idx_q - IW'(1));
				ram_wdata = rem_q[TW-1:0];
			end
			default: begin
			end
		endcase
	end

	pisg_ram #(
		.WIDTH (TW),
		.DEPTH (MAX_TERMS)
	) u_term_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(idx_q - IW'(1))),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			phase_q      <= PH_COMPUTE;
			term_count_q <= TERM_COUNT_RST;
			clr_addr_q   <= '0;
			pend_q       <= 1'b0;
			idx_q        <= '0;
			carry_q      <= '0;
			final_q      <= 1'b0;
			k_q          <= '0;
			nines_q      <= '0;
			run_q        <= '0;
			pred_q       <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				term_count_q <= term_count;
			end
			// the emit state refills the output register itself
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					// sweep every term back to 2
					if (clr_addr_q == AW'(MAX_TERMS - 1)) begin
						clr_addr_q <= '0;
						state_q    <= pend_q ? ST_DISPATCH : ST_IDLE;
						pend_q     <= 1'b0;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							phase_q <= PH_COMPUTE;
							nines_q <= '0;
							run_q   <= '0;
							pred_q  <= '0;
							ovf_q   <= 1'b0;
							pend_q  <= 1'b1;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_DISPATCH;
						end
					end
				end
				ST_DISPATCH: begin
					// pass start values, used when a pass follows
					idx_q   <= active_c;
					carry_q <= '0;
					final_q <= 1'b0;
					priority if (phase_q == PH_ZEROS && run_q < nines_q) begin
						run_q   <= run_q + NINES_W'(1);
						res_q   <= DIGIT_ZERO;
						state_q <= ST_EMIT;
					end else if (phase_q == PH_NINES && run_q < nines_q) begin
						run_q   <= run_q + NINES_W'(1);
						res_q   <= DIGIT_NINE;
						state_q <= ST_EMIT;
					end else begin
						// run of zeros also drops the predigit
						if (phase_q == PH_ZEROS) begin
							pred_q <= '0;
						end
						if (phase_q == PH_ZEROS || phase_q == PH_NINES) begin
							nines_q <= '0;
							run_q   <= '0;
						end
						phase_q <= PH_COMPUTE;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					rem_q   <= x_c;
					div_q   <= {idx_q, 1'b0} - DW'(1);
					dsh_q   <= XW'({idx_q, 1'b0} - DW'(1)) << (QSTEPS - 1);
					k_q     <= KW'(QSTEPS - 1);
					if ({{(64 - XW){1'b0}}, x_c} > PREC_BOUND) begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (ge_c) begin
						rem_q <= rem_sub_c;
					end
					quot_q <= {quot_q[CARRY_W-2:0], ge_c};
					dsh_q  <= dsh_q >> 1;
					k_q    <= k_q - KW'(1);
					if (k_q == '0) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (!final_q) begin
						carry_q <= quot_q;
						if (idx_q == IW'(1)) begin
							// last carry split into digit and term 0
							final_q <= 1'b1;
							rem_q   <= XW'(quot_q);
							div_q   <= DW'(RADIX);
							dsh_q   <= XW'(RADIX) << (QSTEPS - 1);
							k_q     <= KW'(QSTEPS - 1);
							state_q <= ST_DIV;
						end else begin
							idx_q   <= idx_q - IW'(1);
							state_q <= ST_READ;
						end
					end else begin
						// phase is still compute while passes run
						final_q <= 1'b0;
						priority if (quot_q == CARRY_NINE && nines_q != NINES_MAX) begin
							// hold the nine and run another pass
							nines_q <= nines_q + NINES_W'(1);
							idx_q   <= active_c;
							carry_q <= '0;
							state_q <= ST_READ;
						end else if (quot_q == CARRY_TEN) begin
							res_q   <= (pred_q == DIGIT_NINE) ? DIGIT_NINE
								: pred_q + DIGIT_W'(1);
							run_q   <= '0;
							phase_q <= PH_ZEROS;
							state_q <= ST_EMIT;
						end else begin
							res_q   <= pred_q;
							pred_q  <= (quot_q > CARRY_NINE) ? DIGIT_NINE
								: quot_q[DIGIT_W-1:0];
							if (nines_q != '0) begin
								run_q   <= '0;
								phase_q <= PH_NINES;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					// output register frees up or is empty
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						digit_q     <= res_q;
						oflag_q     <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// released run never passes the held nine count
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= nines_q)
		else $error("run counter above held nines");

	// divide leaves a remainder below its divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> rem_q < XW'(div_q))
		else $error("divide remainder not below divisor");

	// an accepted request drops ready on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after request");

	// released digits stay decimal
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit <= DIGIT_NINE)
		else $error("digit above nine");

endmodule
